// ===== rtl/scfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

   // Pending byte store
   localparam int STORE_DEPTH = 32;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int CNT_W       = STORE_AW + 1;

   // Frame layout
   localparam int MAX_FRAME_BYTES = 32;
   localparam int MIN_FRAME_BYTES = 8;
   localparam int LENGTH_POSITION = 3;
   localparam int MAX_DATA_BYTES  = MAX_FRAME_BYTES - MIN_FRAME_BYTES;
   // checksum low byte sits this many bytes before the end of the frame
   localparam int CSUM_TAIL       = 4;

   localparam logic [7:0] HEADER_RESET = 8'd58;

   // Outcome of one scan step
   localparam logic [1:0] STEP_ADVANCE = 2'd0;
   localparam logic [1:0] STEP_DROP    = 2'd1;
   localparam logic [1:0] STEP_ACCEPT  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic append;     // take the received word into the store and scan it
      logic scan;       // scan the stored word read last cycle
      logic emit;       // move frame words to the output register
      logic read_emit;  // next read address follows the emit index
   } scfr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] step_res;
      logic       scan_more;
      logic       store_full;
      logic       emit_done;
   } scfr_status_type;

endpackage

`default_nettype wire

// ===== rtl/scfr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface scfr_rx_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_frame_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;
   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface scfr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   modport source (output valid, output header_byte, input ready);
   modport sink   (input valid, input header_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sum_checked_frame_receiver_top.sv =====
// Frame receiver for a byte stream with a 16-bit additive checksum.
// req_chan carries received words (rx_byte). The block hunts for the header
// byte, then collects address, command, length L, L data words, checksum low,
// checksum high and two trailer words. A frame whose checksum (16-bit sum of
// address through last data word) matches leaves on rsp_chan word by word,
// header first, with frame_last on its final word.
// csr_chan writes the header byte; it is always ready and takes effect on the
// next word. Write it only while the block is idle.
// Throughput: one received word per cycle while no frame is pending and no rescan
// runs. A completed frame of N words is streamed at one word per cycle while rsp_chan
// is ready; its header word goes from the store through the read register into the
// output register, which drives rsp_chan; req_chan is held off until the final word
// is loaded into the output register.
// On a dropped frame the header is discarded and the stored words after it
// are rescanned from the store at one word per cycle, each word read through
// the registered read port; req_chan is held off during the rescan.
// If rsp_chan stalls, the output register holds its word and emission pauses.
// Reset (synchronous) empties the store, returns to header hunt, clears the
// output valid and sets the header byte to 0x3A.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_receiver_top (
   input  logic          clock,
   input  logic          reset,
   scfr_rx_if.sink       req_chan,
   scfr_frame_if.source  rsp_chan,
   scfr_csr_if.sink      csr_chan
);

   scfr_pkg::scfr_cmd_type    cmd;
   scfr_pkg::scfr_status_type status;
   logic                      req_ready;

   assign req_chan.ready = req_ready;

   scfr_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scfr_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .rx_byte  (req_chan.rx_byte),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

`default_nettype wire

// ===== rtl/scfr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scfr_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              rx_byte,
   scfr_frame_if.source            rsp_chan,
   scfr_csr_if.sink                csr_chan,
   input  scfr_pkg::scfr_cmd_type  cmd,
   output scfr_pkg::scfr_status_type status
);

   localparam int AW = scfr_pkg::STORE_AW;
   localparam int CW = scfr_pkg::CNT_W;

   logic [7:0]    store_mem [scfr_pkg::STORE_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   logic [7:0]    hdr_ff;
   logic [AW-1:0] start_ff, start_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] coll_ff, coll_in;
   logic [15:0]   sum_ff, sum_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    sent_lo_ff, sent_lo_in;
   logic [7:0]    sent_hi_ff, sent_hi_in;
   logic [AW-1:0] emit_idx_ff, emit_idx_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;

   logic          step_en;
   logic [7:0]    step_byte;
   logic [CW-1:0] coll_nx;
   logic [8:0]    pos9;
   logic [8:0]    len9;
   logic          sum_add;
   logic [15:0]   sum_nx;
   logic [1:0]    step_res;
   logic          out_load;
   logic          emit_last;
   logic          emit_done;

   // Configuration register, always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= scfr_pkg::HEADER_RESET;
      end else if (csr_chan.valid) begin
         hdr_ff <= csr_chan.header_byte;
      end
   end

   // Store: write at the tail, registered read with write bypass
   assign wr_addr = start_ff + count_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         store_mem[wr_addr] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && (wr_addr == rd_addr)) begin
         rd_data_ff <= rx_byte;
      end else begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Scan step on the received word or on the word read from the store
   assign step_en   = cmd.append | cmd.scan;
   assign step_byte = cmd.append ? rx_byte : rd_data_ff;
   assign coll_nx   = coll_ff + CW'(1);
   assign pos9      = 9'(coll_ff);
   assign len9      = {1'b0, len_ff};
   assign sum_add   = (pos9 <= 9'(scfr_pkg::LENGTH_POSITION))
                      || (pos9 < len9 + 9'(scfr_pkg::CSUM_TAIL));
   assign sum_nx    = sum_ff + (sum_add ? {8'd0, step_byte} : 16'd0);

   always_comb begin
      if (coll_ff == '0) begin
         step_res = (step_byte == hdr_ff) ? scfr_pkg::STEP_ADVANCE : scfr_pkg::STEP_DROP;
      end else if (coll_ff >= CW'(scfr_pkg::MAX_FRAME_BYTES)) begin
         step_res = scfr_pkg::STEP_DROP;
      end else if (coll_nx < CW'(scfr_pkg::MIN_FRAME_BYTES)) begin
         step_res = scfr_pkg::STEP_ADVANCE;
      end else if (len_ff > 8'(scfr_pkg::MAX_DATA_BYTES)) begin
         step_res = scfr_pkg::STEP_DROP;
      end else if (9'(coll_nx) < len9 + 9'(scfr_pkg::MIN_FRAME_BYTES)) begin
         step_res = scfr_pkg::STEP_ADVANCE;
      end else if ({sent_hi_ff, sent_lo_ff} != sum_nx) begin
         step_res = scfr_pkg::STEP_DROP;
      end else begin
         step_res = scfr_pkg::STEP_ACCEPT;
      end
   end

   // Emit: load the output register whenever it is free
   assign out_load  = cmd.emit && (!out_valid_ff || rsp_chan.ready);
   assign emit_last = (CW'(emit_idx_ff) + CW'(1)) == coll_ff;
   assign emit_done = out_load && emit_last;

   // Next values of the frame tracking state
   always_comb begin
      start_in    = start_ff;
      count_in    = count_ff;
      coll_in     = coll_ff;
      sum_in      = sum_ff;
      len_in      = len_ff;
      sent_lo_in  = sent_lo_ff;
      sent_hi_in  = sent_hi_ff;
      emit_idx_in = emit_idx_ff;

      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end

      if (step_en) begin
         case (step_res)
            scfr_pkg::STEP_ADVANCE: begin
               coll_in = coll_nx;
               if (coll_ff == '0) begin
                  sum_in = '0;
               end else begin
                  sum_in = sum_nx;
                  if (pos9 == 9'(scfr_pkg::LENGTH_POSITION)) begin
                     len_in = step_byte;
                  end
                  if (pos9 > 9'(scfr_pkg::LENGTH_POSITION)) begin
                     if (pos9 == len9 + 9'(scfr_pkg::CSUM_TAIL)) begin
                        sent_lo_in = step_byte;
                     end
                     if (pos9 == len9 + 9'(scfr_pkg::CSUM_TAIL + 1)) begin
                        sent_hi_in = step_byte;
                     end
                  end
               end
            end
            scfr_pkg::STEP_ACCEPT: begin
               coll_in     = coll_nx;
               emit_idx_in = '0;
            end
            default: begin
               // drop the front word and rescan from the next one
               start_in = start_ff + AW'(1);
               count_in = count_in - CW'(1);
               coll_in  = '0;
               sum_in   = '0;
            end
         endcase
      end

      if (out_load) begin
         emit_idx_in = emit_idx_ff + AW'(1);
      end

      // frame delivered: release its words
      if (emit_done) begin
         start_in = start_ff + coll_ff[AW-1:0];
         count_in = count_ff - coll_ff;
         coll_in  = '0;
         sum_in   = '0;
      end
   end

   assign rd_addr = start_in + (cmd.read_emit ? emit_idx_in : coll_in[AW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         count_ff    <= '0;
         coll_ff     <= '0;
         sum_ff      <= '0;
         emit_idx_ff <= '0;
      end else begin
         start_ff    <= start_in;
         count_ff    <= count_in;
         coll_ff     <= coll_in;
         sum_ff      <= sum_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      sent_lo_ff <= sent_lo_in;
      sent_hi_ff <= sent_hi_in;
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff <= rd_data_ff;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_byte = out_byte_ff;
   assign rsp_chan.frame_last = out_last_ff;

   // Status to the controller
   assign status.step_res   = step_res;
   assign status.scan_more  = coll_in < count_in;
   assign status.store_full = count_ff == CW'(scfr_pkg::STORE_DEPTH);
   assign status.emit_done  = emit_done;

endmodule

`default_nettype wire

// ===== rtl/scfr_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scfr_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  scfr_pkg::scfr_status_type status,
   output scfr_pkg::scfr_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   // Accept words only while every stored word has been scanned
   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      cmd.append    = 1'b0;
      cmd.scan      = 1'b0;
      cmd.emit      = 1'b0;
      state_in      = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.append = req_valid && !status.store_full;
            if (cmd.append) begin
               if (status.step_res == scfr_pkg::STEP_ACCEPT) begin
                  state_in = ST_EMIT;
               end else if (status.scan_more) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.step_res == scfr_pkg::STEP_ACCEPT) begin
               state_in = ST_EMIT;
            end else if (!status.scan_more) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_done) begin
               state_in = status.scan_more ? ST_SCAN : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.read_emit = state_in == ST_EMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== test/scfr_frame_checker.sv =====
`timescale 1ns / 1ps

module scfr_frame_checker (
   input  logic  clock,
   input  logic  reset,
   scfr_rx_if    rx,
   scfr_frame_if frame,
   scfr_csr_if   csr,
   output int    error_count,
   output int    outstanding
);

   typedef struct {
      logic [7:0] data;
      logic       is_last;
   } frame_word_type;

   // Shadow copy of the receiver state
   logic [7:0]     header_value;
   logic [7:0]     pending_words [scfr_pkg::STORE_DEPTH];
   logic [4:0]     pending_head;
   logic [5:0]     pending_fill;
   logic [5:0]     taken;
   logic [15:0]    frame_sum;
   frame_word_type frame_words_due [$];
   int             errors;

   function automatic logic [7:0] pending_at(input int pos);
      return pending_words[5'(int'(pending_head) + pos)];
   endfunction

   // Drop words from the front and restart the hunt
   task automatic retire_front(input int n);
      if (n > int'(pending_fill)) n = int'(pending_fill);
      pending_head = 5'(int'(pending_head) + n);
      pending_fill = 6'(int'(pending_fill) - n);
      taken = '0;
      frame_sum = '0;
   endtask

   // Append one received word and scan everything that can be scanned
   task automatic scan_rx_word(input logic [7:0] word);
      int             pos;
      int             len;
      int             total;
      logic [7:0]     w;
      logic [15:0]    sent;
      frame_word_type fw;
      if (int'(pending_fill) < scfr_pkg::STORE_DEPTH) begin
         pending_words[5'(int'(pending_head) + int'(pending_fill))] = word;
         pending_fill = pending_fill + 6'd1;
      end
      while (taken < pending_fill) begin
         // hunt for the header
         if (taken == 0) begin
            if (pending_at(0) != header_value) begin
               retire_front(1);
            end else begin
               taken = 6'd1;
               frame_sum = '0;
            end
            continue;
         end
         if (int'(taken) >= scfr_pkg::MAX_FRAME_BYTES) begin
            retire_front(1);
            continue;
         end
         pos = int'(taken);
         w = pending_at(pos);
         taken = taken + 6'd1;
         if (pos <= scfr_pkg::LENGTH_POSITION) begin
            frame_sum = frame_sum + 16'(w);
         end else begin
            len = int'(pending_at(scfr_pkg::LENGTH_POSITION));
            if (pos < len + scfr_pkg::MIN_FRAME_BYTES - scfr_pkg::CSUM_TAIL)
               frame_sum = frame_sum + 16'(w);
         end
         if (int'(taken) < scfr_pkg::MIN_FRAME_BYTES) continue;
         len = int'(pending_at(scfr_pkg::LENGTH_POSITION));
         if (len > scfr_pkg::MAX_DATA_BYTES) begin
            retire_front(1);
            continue;
         end
         total = len + scfr_pkg::MIN_FRAME_BYTES;
         if (int'(taken) < total) continue;
         sent = {pending_at(total - scfr_pkg::CSUM_TAIL + 1),
                 pending_at(total - scfr_pkg::CSUM_TAIL)};
         if (sent != frame_sum) begin
            retire_front(1);
            continue;
         end
         // good frame: queue every word, header first
         for (int k = 0; k < total; k++) begin
            fw.data = pending_at(k);
            fw.is_last = (k == total - 1);
            frame_words_due.push_back(fw);
         end
         retire_front(total);
      end
   endtask

   // Compare one emitted word with the oldest expected word
   task automatic check_frame_word();
      frame_word_type fw;
      if (frame_words_due.size() == 0) begin
         $error("unexpected frame word: frame_byte %h frame_last %b",
                frame.frame_byte, frame.frame_last);
         errors++;
      end else begin
         fw = frame_words_due.pop_front();
         if (frame.frame_byte !== fw.data) begin
            $error("frame_byte mismatch: expected %h, actual %h", fw.data, frame.frame_byte);
            errors++;
         end
         if (frame.frame_last !== fw.is_last) begin
            $error("frame_last mismatch: expected %b, actual %b",
                   fw.is_last, frame.frame_last);
            errors++;
         end
      end
   endtask

   initial begin
      errors = 0;
      error_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         header_value = scfr_pkg::HEADER_RESET;
         pending_head = '0;
         pending_fill = '0;
         taken = '0;
         frame_sum = '0;
         frame_words_due.delete();
      end else begin
         if (frame.valid && frame.ready) check_frame_word();
         if (csr.valid && csr.ready) header_value = csr.header_byte;
         if (rx.valid && rx.ready) scan_rx_word(rx.rx_byte);
      end
      error_count <= errors;
      outstanding <= frame_words_due.size();
   end

endmodule

// ===== test/sum_checked_frame_receiver_top_tb.sv =====
`timescale 1ns / 1ps

module sum_checked_frame_receiver_top_tb;

   typedef logic [7:0] word_q_type [$];

   localparam int RESET_CYCLES = 10;
   localparam int WORDS_PER_PHASE = 70;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES = 250;
   localparam int STALL_LIMIT = 2000;

   logic clock;
   logic reset;
   bit   calm;
   bit   hold_request;
   int   error_count;
   int   outstanding;
   word_q_type tx_words;

   scfr_rx_if    rx_chan ();
   scfr_frame_if frame_chan ();
   scfr_csr_if   csr_chan ();

   sum_checked_frame_receiver_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (rx_chan),
      .rsp_chan (frame_chan),
      .csr_chan (csr_chan)
   );

   scfr_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .rx          (rx_chan),
      .frame       (frame_chan),
      .csr         (csr_chan),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Build one frame with the given fields and payload
   function automatic word_q_type frame_words(input logic [7:0] hdr, input logic [7:0] addr,
                                              input logic [7:0] cmd, input word_q_type payload,
                                              input bit bad_sum);
      word_q_type  q;
      logic [15:0] s;
      s = 16'(addr) + 16'(cmd) + 16'(payload.size());
      q.push_back(hdr);
      q.push_back(addr);
      q.push_back(cmd);
      q.push_back(8'(payload.size()));
      foreach (payload[i]) begin
         s = s + 16'(payload[i]);
         q.push_back(payload[i]);
      end
      // flip one checksum bit to force a mismatch
      if (bad_sum) s = s ^ (16'd1 << $urandom_range(15));
      q.push_back(s[7:0]);
      q.push_back(s[15:8]);
      q.push_back(8'($urandom));
      q.push_back(8'($urandom));
      return q;
   endfunction

   function automatic word_q_type random_payload(input int len);
      word_q_type q;
      for (int i = 0; i < len; i++) q.push_back(8'($urandom));
      return q;
   endfunction

   task automatic queue_words(input word_q_type q);
      foreach (q[i]) tx_words.push_back(q[i]);
   endtask

   // Mostly well-formed frames, plus broken frames and line noise
   task automatic queue_random_traffic(input logic [7:0] hdr);
      int         r;
      int         len;
      word_q_type inner;
      while (tx_words.size() < WORDS_PER_PHASE) begin
         r = $urandom_range(99);
         len = ($urandom_range(99) < 80) ? $urandom_range(0, 6)
                                         : $urandom_range(7, scfr_pkg::MAX_DATA_BYTES);
         if (r < 55) begin
            queue_words(frame_words(hdr, 8'($urandom), 8'($urandom), random_payload(len), 0));
         end else if (r < 67) begin
            queue_words(frame_words(hdr, 8'($urandom), 8'($urandom), random_payload(len), 1));
         end else if (r < 75) begin
            // declared length too large
            tx_words.push_back(hdr);
            tx_words.push_back(8'($urandom));
            tx_words.push_back(8'($urandom));
            tx_words.push_back(8'($urandom_range(scfr_pkg::MAX_DATA_BYTES + 1, 255)));
            queue_words(random_payload(4));
         end else if (r < 85) begin
            queue_words(random_payload($urandom_range(1, 4)));
         end else if (r < 92) begin
            // stray header ahead of a good frame
            tx_words.push_back(hdr);
            queue_words(frame_words(hdr, 8'($urandom), 8'($urandom), random_payload(len), 0));
         end else begin
            // bad frame that hides two good frames in its payload
            inner = frame_words(hdr, 8'($urandom), 8'($urandom), random_payload(0), 0);
            inner = {inner, frame_words(hdr, 8'($urandom), 8'($urandom), random_payload(0), 0)};
            queue_words(frame_words(hdr, 8'($urandom), 8'($urandom), inner, 1));
         end
      end
   endtask

   // Offer one word and hold it until taken; idle now and then
   task automatic send_word(input logic [7:0] word);
      rx_chan.valid <= 1'b1;
      rx_chan.rx_byte <= word;
      do @(posedge clock); while (!rx_chan.ready);
      if (!calm && $urandom_range(99) < 25) begin
         rx_chan.valid <= 1'b0;
         rx_chan.rx_byte <= 8'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_queued();
      while (tx_words.size() > 0) send_word(tx_words.pop_front());
      rx_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.header_byte <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every expected word, then let any rescan finish
   task automatic drain();
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      frame_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            frame_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         frame_chan.ready <= !reset && (calm || $urandom_range(99) >= 20);
      end
   end

   // Stop if nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((rx_chan.valid && rx_chan.ready) || (frame_chan.valid && frame_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("sum_checked_frame_receiver_top_tb: done, errors");
      $finish;
   end

   initial begin
      logic [7:0] hdr;
      calm = 1'b0;
      hold_request = 1'b0;
      reset <= 1'b1;
      rx_chan.valid <= 1'b0;
      rx_chan.rx_byte <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.header_byte <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset header: field extremes, oversize length, bad checksum, a maximum-length frame, random traffic
      hdr = scfr_pkg::HEADER_RESET;
      queue_words(frame_words(hdr, 8'hFF, 8'h00, random_payload(0), 0));
      tx_words.push_back(hdr);
      tx_words.push_back(8'h00);
      tx_words.push_back(8'hFF);
      tx_words.push_back(8'hFF);
      queue_words(random_payload(4));
      queue_words(frame_words(hdr, 8'h00, 8'hFF, random_payload(0), 1));
      send_queued();
      queue_words(frame_words(hdr, 8'($urandom), 8'($urandom),
                              random_payload(scfr_pkg::MAX_DATA_BYTES), 0));
      queue_random_traffic(hdr);
      send_queued();
      drain();

      // Header 0x00 with a long receiver hold-off
      hdr = 8'h00;
      write_header(hdr);
      hold_request = 1'b1;
      queue_random_traffic(hdr);
      send_queued();
      drain();

      // Header 0xFF
      hdr = 8'hFF;
      write_header(hdr);
      queue_random_traffic(hdr);
      send_queued();
      drain();

      // Random header, no idling on either side
      hdr = 8'($urandom);
      write_header(hdr);
      calm = 1'b1;
      queue_random_traffic(hdr);
      send_queued();
      drain();
      calm = 1'b0;

      // Back to the reset header
      hdr = scfr_pkg::HEADER_RESET;
      write_header(hdr);
      queue_random_traffic(hdr);
      send_queued();
      drain();

      if (error_count == 0)
         $display("sum_checked_frame_receiver_top_tb: done, clean");
      else
         $display("sum_checked_frame_receiver_top_tb: done, errors");
      $finish;
   end

endmodule
